// ===== src/sacl_pkg.sv =====
// constants and types for the set-associative cache lookup with lru replacement
// no dependencies; imported by set_assoc_cache_lru_lookup_top, lru_lookup_checker and testbench
package sacl_pkg;

    localparam int MAX_SETS = 64;
    localparam int MAX_WAYS = 8;

    localparam int ADDR_W   = 32;
    localparam int SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RANK_W   = WAY_W;
    localparam int CNT_W    = $clog2(ADDR_W);

    localparam int CFG_SETS_W  = 7;
    localparam int CFG_WAYS_W  = 4;
    localparam int CFG_DATA_W  = 7;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_NUM_SETS = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_NUM_WAYS = CFG_INDEX_W'(1);

    localparam logic [CFG_SETS_W-1:0] NUM_SETS_RST = CFG_SETS_W'(64);
    localparam logic [CFG_WAYS_W-1:0] NUM_WAYS_RST = CFG_WAYS_W'(8);

    typedef logic [RANK_W-1:0] rank_t;
    typedef logic [ADDR_W-1:0] tag_t;
    typedef rank_t [MAX_WAYS-1:0] rank_row_t;
    typedef tag_t [MAX_WAYS-1:0] tag_row_t;

endpackage

// ===== src/set_assoc_cache_lru_lookup_top.sv =====
// an accepted item passes through the bit-serial divider (32 steps, one quotient bit
// per cycle), then the set read and the lookup/update, which waits for room in the result
// register; a new item is accepted only after the last one has committed its result
// reset: async active low; clears control, config to 64 sets / 8 ways and marks
// all sets empty through per-set flags, so no clearing pass is needed
// uses sacl_pkg
module set_assoc_cache_lru_lookup_top
    import sacl_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [ADDR_W-1:0]      address,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   hit,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_RD   = 2'd2;
    localparam logic [1:0] ST_LOOK = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [CFG_SETS_W-1:0] num_sets_reg;
    logic [CFG_WAYS_W-1:0] num_ways_reg;
    logic [ADDR_W-1:0]     quo_reg;
    logic [SET_W-1:0]      rem_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  out_valid_reg;
    logic                  hit_reg;
    logic [MAX_SETS-1:0]   row_init_reg;
    logic                  row_ok_reg;

    logic [MAX_WAYS-1:0]   vld_mem [MAX_SETS];
    rank_row_t             rank_mem [MAX_SETS];
    tag_row_t              tag_mem [MAX_SETS];
    logic [MAX_WAYS-1:0]   vld_rd_reg;
    rank_row_t             rank_rd_reg;
    tag_row_t              tag_rd_reg;

    logic [SET_W:0]        sets_use;
    logic [WAY_W:0]        ways_use;
    logic [SET_W:0]        rem_sh;
    logic                  rem_ge;
    logic [MAX_WAYS-1:0]   in_use;
    logic [MAX_WAYS-1:0]   vld_eff;
    rank_row_t             rank_eff;
    logic                  look_hit;
    logic                  found_hit;
    logic                  found_free;
    logic [WAY_W-1:0]      hit_way;
    logic [WAY_W-1:0]      free_way;
    logic [WAY_W-1:0]      victim;
    logic [WAY_W-1:0]      touched;
    logic [RANK_W:0]       old_rank;
    logic [MAX_WAYS-1:0]   vld_new;
    rank_row_t             rank_new;
    tag_row_t              tag_new;
    logic                  commit;

    // clamp config to the supported ranges
    always_comb
    begin
        if (num_sets_reg == '0)
            sets_use = (SET_W+1)'(1);
        else if ({1'b0, num_sets_reg} > (CFG_SETS_W+1)'(MAX_SETS))
            sets_use = (SET_W+1)'(MAX_SETS);
        else
            sets_use = (SET_W+1)'(num_sets_reg);
        if (num_ways_reg == '0)
            ways_use = (WAY_W+1)'(1);
        else if ({1'b0, num_ways_reg} > (CFG_WAYS_W+1)'(MAX_WAYS))
            ways_use = (WAY_W+1)'(MAX_WAYS);
        else
            ways_use = (WAY_W+1)'(num_ways_reg);
    end

    // restoring divider step
    assign rem_sh = {rem_reg, quo_reg[ADDR_W-1]};
    assign rem_ge = rem_sh >= sets_use;

    // lookup of the set row
    always_comb
    begin
        vld_eff    = row_ok_reg ? vld_rd_reg : '0;
        rank_eff   = row_ok_reg ? rank_rd_reg : '0;
        found_hit  = 1'b0;
        found_free = 1'b0;
        hit_way    = '0;
        free_way   = '0;
        victim     = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            in_use[w] = (WAY_W+1)'(w) < ways_use;
            if (!found_hit && in_use[w] && vld_eff[w] && tag_rd_reg[w] == quo_reg)
            begin
                found_hit = 1'b1;
                hit_way   = WAY_W'(w);
            end
            if (!found_free && in_use[w] && !vld_eff[w])
            begin
                found_free = 1'b1;
                free_way   = WAY_W'(w);
            end
            if (in_use[w] && rank_eff[w] > rank_eff[victim])
                victim = WAY_W'(w);
        end
        look_hit = found_hit;
        priority if (found_hit)
            touched = hit_way;
        else if (found_free)
            touched = free_way;
        else
            touched = victim;
        old_rank = found_hit ? {1'b0, rank_eff[touched]} : (RANK_W+1)'(MAX_WAYS);
        vld_new  = vld_eff;
        rank_new = rank_eff;
        tag_new  = tag_rd_reg;
        for (int j = 0; j < MAX_WAYS; j++)
        begin
            if (in_use[j] && vld_eff[j] && WAY_W'(j) != touched
                && {1'b0, rank_eff[j]} < old_rank
                && rank_eff[j] < RANK_W'(MAX_WAYS - 1))
                rank_new[j] = rank_eff[j] + RANK_W'(1);
        end
        rank_new[touched] = '0;
        vld_new[touched]  = 1'b1;
        tag_new[touched]  = quo_reg;
    end

    assign commit = (state_reg == ST_LOOK) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(ADDR_W - 1))
                    state_next = ST_RD;
            end
            ST_RD:
            begin
                state_next = ST_LOOK;
            end
            ST_LOOK:
            begin
                if (commit)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            num_sets_reg  <= NUM_SETS_RST;
            num_ways_reg  <= NUM_WAYS_RST;
            out_valid_reg <= 1'b0;
            row_init_reg  <= '0;
            row_ok_reg    <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_NUM_SETS)
                    num_sets_reg <= cfg_data[CFG_SETS_W-1:0];
                else if (cfg_index == REG_NUM_WAYS)
                    num_ways_reg <= cfg_data[CFG_WAYS_W-1:0];
            end
            if (state_reg == ST_IDLE)
                cnt_reg <= '0;
            else if (state_reg == ST_DIV)
                cnt_reg <= cnt_reg + CNT_W'(1);
            if (state_reg == ST_RD)
                row_ok_reg <= row_init_reg[rem_reg];
            if (commit)
            begin
                out_valid_reg         <= 1'b1;
                row_init_reg[rem_reg] <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // divider datapath and result register
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            quo_reg <= address;
            rem_reg <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            quo_reg <= {quo_reg[ADDR_W-2:0], rem_ge};
            rem_reg <= rem_ge ? SET_W'(rem_sh - sets_use) : rem_sh[SET_W-1:0];
        end
        if (commit)
            hit_reg <= look_hit;
    end

    // set memories
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RD)
        begin
            vld_rd_reg  <= vld_mem[rem_reg];
            rank_rd_reg <= rank_mem[rem_reg];
            tag_rd_reg  <= tag_mem[rem_reg];
        end
        if (commit)
        begin
            vld_mem[rem_reg]  <= vld_new;
            rank_mem[rem_reg] <= rank_new;
            tag_mem[rem_reg]  <= tag_new;
        end
    end

    // register writes go first and only while no item is in the divider
    assign in_ready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign cfg_ready = (state_reg == ST_IDLE);

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_DIV)
        else $error("item accepted but divider not started");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RD |-> {1'b0, rem_reg} < sets_use)
        else $error("set index not below set count");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOOK |-> (WAY_W+1)'(touched) < ways_use)
        else $error("touched way outside ways in use");

    assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid && !in_ready == 1'b0)
        else $error("result not presented after commit");
`endif

endmodule

// ===== dv/lru_lookup_checker.sv =====
// checker for the set-associative cache lookup: watches the lookup, result and register channels
// keeps its own copy of tags, valid bits and lru ranks and compares every hit result
// depends on sacl_pkg
`timescale 1ns / 1ps

module lru_lookup_checker
    import sacl_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic [ADDR_W-1:0]      address,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic                   hit,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int unsigned            hits_outstanding,
    output int unsigned            mismatches
);

    localparam int LINES = MAX_SETS * MAX_WAYS;

    logic [CFG_SETS_W-1:0] sets_reg;
    logic [CFG_WAYS_W-1:0] ways_reg;
    bit                    line_valid [LINES];
    tag_t                  line_tag   [LINES];
    rank_t                 line_rank  [LINES];
    bit                    hit_expected_q [$];
    bit                    hit_wanted;

    initial mismatches = 0;

    task automatic report_mismatch(input string what);
        $display("%0t ns: %s", $time, what);
        mismatches++;
    endtask

    function automatic void clear_cache();
        sets_reg = NUM_SETS_RST;
        ways_reg = NUM_WAYS_RST;
        for (int i = 0; i < LINES; i++)
        begin
            line_valid[i] = 1'b0;
            line_tag[i]   = '0;
            line_rank[i]  = '0;
        end
    endfunction

    function automatic void write_register(input logic [CFG_INDEX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_NUM_SETS: sets_reg = data;
            REG_NUM_WAYS: ways_reg = data[CFG_WAYS_W-1:0];
            default: ;
        endcase
    endfunction

    // make way w most recently used, aging the ways that were younger
    function automatic void make_mru(input int unsigned base, input int unsigned w,
                                     input int unsigned ways, input bit was_valid);
        int unsigned old_rank;
        old_rank = was_valid ? int'(line_rank[base + w]) : MAX_WAYS;
        for (int unsigned j = 0; j < ways; j++)
        begin
            if (j != w && line_valid[base + j] && line_rank[base + j] < old_rank
                    && line_rank[base + j] < MAX_WAYS - 1)
                line_rank[base + j] = line_rank[base + j] + 1'b1;
        end
        line_rank[base + w] = '0;
    endfunction

    function automatic bit predict_hit(input logic [ADDR_W-1:0] addr);
        int unsigned sets;
        int unsigned ways;
        int unsigned base;
        int unsigned victim;
        tag_t        tag;
        sets = (sets_reg == 0) ? 1 : ((sets_reg > MAX_SETS) ? MAX_SETS : sets_reg);
        ways = (ways_reg == 0) ? 1 : ((ways_reg > MAX_WAYS) ? MAX_WAYS : ways_reg);
        base = (addr % sets) * MAX_WAYS;
        tag  = addr / sets;
        for (int unsigned w = 0; w < ways; w++)
        begin
            if (line_valid[base + w] && line_tag[base + w] == tag)
            begin
                make_mru(base, w, ways, 1'b1);
                return 1'b1;
            end
        end
        for (int unsigned w = 0; w < ways; w++)
        begin
            if (!line_valid[base + w])
            begin
                make_mru(base, w, ways, 1'b0);
                line_valid[base + w] = 1'b1;
                line_tag[base + w]   = tag;
                return 1'b0;
            end
        end
        // ties go to the lowest way
        victim = 0;
        for (int unsigned w = 1; w < ways; w++)
        begin
            if (line_rank[base + w] > line_rank[base + victim])
                victim = w;
        end
        make_mru(base, victim, ways, 1'b0);
        line_tag[base + victim] = tag;
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cache();
            hit_expected_q.delete();
            hits_outstanding <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (hit_expected_q.size() == 0)
                    report_mismatch($sformatf("result hit=%0b with no lookup waiting", hit));
                else
                begin
                    hit_wanted = hit_expected_q.pop_front();
                    if (hit !== hit_wanted)
                        report_mismatch($sformatf("hit=%0b, expected %0b", hit, hit_wanted));
                end
            end
            if (cfg_valid && cfg_ready)
                write_register(cfg_index, cfg_data);
            if (in_valid && in_ready)
                hit_expected_q.push_back(predict_hit(address));
            hits_outstanding <= hit_expected_q.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
// top of the cache lookup testbench: clock, reset, lookup and register stimulus, verdict
// depends on sacl_pkg, set_assoc_cache_lru_lookup_top and lru_lookup_checker
`timescale 1ns / 1ps

module testbench;
    import sacl_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER  = 40;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 38;
    localparam int DRAIN       = 40;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = CFG_INDEX_W'(3);

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    logic [ADDR_W-1:0]      address   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   hit;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int unsigned hits_outstanding;
    int unsigned mismatches;
    int unsigned quiet_cycles = 0;
    bit          calm = 1'b0;

    int unsigned phase_sets [8] = '{64, 1, 1, 64, 3, 37, 7, 64};
    int unsigned phase_ways [8] = '{8, 1, 8, 1, 4, 3, 5, 2};

    always #10 clk = ~clk;

    set_assoc_cache_lru_lookup_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .address   (address),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .hit       (hit),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lru_lookup_checker lru_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .address          (address),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .hit              (hit),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .hits_outstanding (hits_outstanding),
        .mismatches       (mismatches)
    );

    task automatic send_address(input logic [ADDR_W-1:0] a);
        int unsigned gap;
        gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        address  <= a;
        do @(posedge clk); while (!in_ready);
    endtask

    // registers change only once every lookup has returned its result
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        in_valid <= 1'b0;
        do @(posedge clk); while (hits_outstanding != 0);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [ADDR_W-1:0]     pool [32];
        logic [ADDR_W-1:0]     a;
        logic [ADDR_W-1:0]     tag_part;
        logic [CFG_DATA_W-1:0] sets_data;
        logic [CFG_DATA_W-1:0] ways_data;
        int unsigned           n_pool;
        int unsigned           hot;
        int unsigned           eff_sets;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty cache, repeats and the address extremes
        send_address('0);
        send_address('0);
        send_address('1);
        send_address('1);
        // fill one set past its ways so the lru way is replaced
        for (int k = 0; k < 9; k++)
            send_address(ADDR_W'(5 + 64 * k));
        send_address(ADDR_W'(5 + 64));
        send_address(ADDR_W'(5));
        // fewer ways with old state kept, rank ties possible
        write_reg(REG_NUM_WAYS, 7'h02);
        send_address(ADDR_W'(5 + 64 * 3));
        send_address(ADDR_W'(5 + 64 * 3));
        // zero registers clamp to one set and one way
        write_reg(REG_NUM_SETS, 7'h00);
        write_reg(REG_NUM_WAYS, 7'h70);
        send_address(32'h1234_5678);
        send_address(32'h1234_5678);
        send_address(32'hA5A5_A5A5);
        // oversize registers clamp to the maximum
        write_reg(REG_NUM_SETS, 7'h7F);
        write_reg(REG_NUM_WAYS, 7'h7F);
        send_address('1);
        send_address(32'h8000_0000);
        // unused register indexes
        write_reg(REG_SPARE_A, 7'h55);
        write_reg(REG_SPARE_B, 7'h2A);
        send_address('0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph < 8)
            begin
                sets_data = CFG_DATA_W'(phase_sets[ph]);
                ways_data = {3'($urandom), 4'(phase_ways[ph])};
            end
            else
            begin
                sets_data = CFG_DATA_W'($urandom);
                ways_data = CFG_DATA_W'($urandom);
            end
            write_reg(REG_NUM_SETS, sets_data);
            write_reg(REG_NUM_WAYS, ways_data);
            if (ph == PHASES - 1)
                calm <= 1'b1;
            eff_sets = (sets_data == 0) ? 1 : ((sets_data > MAX_SETS) ? MAX_SETS : sets_data);

            // working set crowded into a few sets so ways fill and get replaced
            n_pool = $urandom_range(4, 24);
            hot    = $urandom_range(1, 4);
            for (int i = 0; i < n_pool; i++)
            begin
                tag_part = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 15);
                pool[i]  = tag_part * eff_sets + ($urandom_range(0, hot - 1) % eff_sets);
            end

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                case ($urandom_range(0, 9))
                    0, 1: a = $urandom;
                    2:
                    begin
                        case ($urandom_range(0, 3))
                            0: a = '0;
                            1: a = '1;
                            2: a = 32'h8000_0000;
                            default: a = ADDR_W'(eff_sets - 1);
                        endcase
                    end
                    default: a = pool[$urandom_range(0, n_pool - 1)];
                endcase
                send_address(a);
            end
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (hits_outstanding != 0);
        repeat (DRAIN) @(posedge clk);
        if (mismatches == 0)
            $display("set_assoc_cache_lru_lookup_top: match");
        else
            $display("set_assoc_cache_lru_lookup_top: mismatch");
        $finish;
    end

    initial
    begin
        int unsigned burst;
        int unsigned results_seen;
        bit          held;
        burst        = 0;
        results_seen = 0;
        held         = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                results_seen++;
            if (!held && results_seen == HOLD_AFTER)
            begin
                // long hold so the block backs up and stalls its input
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (burst > 0)
            begin
                burst--;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                burst = $urandom_range(0, 2);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("set_assoc_cache_lru_lookup_top: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

// ===== filelist.f =====
src/sacl_pkg.sv
src/set_assoc_cache_lru_lookup_top.sv
dv/lru_lookup_checker.sv
dv/testbench.sv
